@@ src/assert_macros.svh @@
// Concurrent assertion helpers shared by the RTL.
// Each takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/hlpc_pkg.sv @@
`default_nettype none

package hlpc_pkg;

    // Band edges in hertz, highest frequency (lowest humidity) first.
    localparam logic [12:0] BAND_EDGE [0:10] = '{
        13'd6852, 13'd6734, 13'd6618, 13'd6503, 13'd6388, 13'd6271,
        13'd6152, 13'd6029, 13'd5901, 13'd5766, 13'd5623
    };

    localparam logic [12:0] EDGE_TOP    = 13'd6852;
    localparam logic [12:0] EDGE_BOTTOM = 13'd5623;

    localparam logic [7:0]  DAC_TOP     = 8'd155;
    localparam logic [6:0]  DRIVE_CAP   = 7'd100;
    localparam logic [6:0]  HUMID_MAX   = 7'd99;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 16-bit x
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [6:0]  TARGET_RESET = 7'd50;
    localparam logic [7:0]  GAIN_RESET   = 8'd10;
    localparam logic [9:0]  OFFSET_RESET = 10'd100;

    typedef enum logic [1:0] {
        REG_TARGET_HUMIDITY = 2'd0,
        REG_PROP_GAIN       = 2'd1,
        REG_COUNT_OFFSET    = 2'd2
    } reg_index_t;

    // Width of band k in hertz (k in 0..9).
    function automatic logic [7:0] band_width(input logic [3:0] k);
        logic [12:0] hi;
        logic [12:0] lo;
        hi = BAND_EDGE[k];
        lo = BAND_EDGE[k + 4'd1];
        return 8'(hi - lo);
    endfunction

    // j times the width of band k: threshold for the units digit to reach j.
    function automatic logic [10:0] unit_thr(input logic [3:0] k, input logic [3:0] j);
        logic [10:0] w;
        w = 11'(band_width(k));
        return 11'(w * 11'(j));
    endfunction

endpackage

`default_nettype wire

@@ src/humidity_linearize_p_control.sv @@
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------------
//  in       | sink      | in_valid / in_stall  | pulse_count[15:0]
//  out      | source    | out_valid / out_stall| humidity[6:0], drive_level[6:0],
//           |           |                      | dac_code[7:0]
//  cfg      | APB slave | psel/penable/pready  | paddr[3:0], pwdata/prdata[31:0]
//
//  Six register stages, one transaction enters per cycle while in_stall is low;
//  out_valid rises once the result reaches the output register.
//  Reset (rst_n low, asynchronous) empties the pipeline and loads the register
//  defaults: target 50, gain 10, offset 100.
//  A stall on the output freezes only the stages that are full up to the first
//  bubble; in_stall rises only when stage one is full and cannot advance.

`default_nettype none

module humidity_linearize_p_control (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pulse_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  humidity,
    output logic [6:0]  drive_level,
    output logic [7:0]  dac_code,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] target_reg;
    logic [7:0] gain_reg;
    logic [9:0] offset_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    // Write at the access phase; unknown addresses drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= hlpc_pkg::TARGET_RESET;
            gain_reg   <= hlpc_pkg::GAIN_RESET;
            offset_reg <= hlpc_pkg::OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                hlpc_pkg::REG_TARGET_HUMIDITY: target_reg <= pwdata[6:0];
                hlpc_pkg::REG_PROP_GAIN:       gain_reg   <= pwdata[7:0];
                hlpc_pkg::REG_COUNT_OFFSET:    offset_reg <= pwdata[9:0];
                default:                       ;
            endcase
        end
    end

    // Read back the addressed register, zero elsewhere.
    always_comb
    begin
        case (paddr[3:2])
            hlpc_pkg::REG_TARGET_HUMIDITY: prdata = 32'(target_reg);
            hlpc_pkg::REG_PROP_GAIN:       prdata = 32'(gain_reg);
            hlpc_pkg::REG_COUNT_OFFSET:    prdata = 32'(offset_reg);
            default:                       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when empty or when the next
    // stage advances. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [6:1] vld_reg;
    logic [6:1] vld_next;
    logic [6:1] adv;

    assign adv[6] = !vld_reg[6] || !out_stall;
    assign adv[5] = !vld_reg[5] || adv[6];
    assign adv[4] = !vld_reg[4] || adv[5];
    assign adv[3] = !vld_reg[3] || adv[4];
    assign adv[2] = !vld_reg[2] || adv[3];
    assign adv[1] = !vld_reg[1] || adv[2];

    assign in_stall  = !adv[1];
    assign out_valid = vld_reg[6];

    always_comb
    begin
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= 6; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: remove the calibration offset, wrapping modulo 2^16.
    // ------------------------------------------------------------------
    logic [15:0] freq_reg;
    logic [15:0] freq_next;

    assign freq_next = pulse_count - 16'(offset_reg);

    // ------------------------------------------------------------------
    // Stage 2: range check, band index and distance below the band top.
    // Edges fall with k, so the count of edges 1..9 below f is 9 - k.
    // ------------------------------------------------------------------
    logic        inrng_reg;
    logic        inrng_next;
    logic [3:0]  band_reg;
    logic [3:0]  band_next;
    logic [7:0]  dist_reg;
    logic [7:0]  dist_next;
    logic [3:0]  n_above;
    logic [12:0] band_top;

    always_comb
    begin
        inrng_next = (freq_reg >= 16'(hlpc_pkg::EDGE_BOTTOM)) &&
                     (freq_reg <= 16'(hlpc_pkg::EDGE_TOP));
        n_above = 4'd0;
        for (int j = 1; j <= 9; j++)
        begin
            n_above = n_above + 4'(freq_reg > 16'(hlpc_pkg::BAND_EDGE[j]));
        end
        band_next = 4'd9 - n_above;
        band_top  = hlpc_pkg::BAND_EDGE[band_next];
        dist_next = 8'(band_top - freq_reg[12:0]);
    end

    // ------------------------------------------------------------------
    // Stage 3: units digit = floor(dist*10 / width), found by comparing
    // dist*10 against j*width for j = 1..10; then zero out of range, else saturate at 99.
    // ------------------------------------------------------------------
    logic [6:0]  hum_reg;
    logic [6:0]  hum_next;
    logic [10:0] dist10;
    logic [3:0]  units;
    logic [6:0]  hum_raw;

    always_comb
    begin
        dist10 = 11'({dist_reg, 3'b000}) + 11'({dist_reg, 1'b0});
        units  = 4'd0;
        for (int j = 1; j <= 10; j++)
        begin
            units = units + 4'(dist10 >= hlpc_pkg::unit_thr(band_reg, 4'(j)));
        end
        hum_raw = 7'(band_reg) * 7'd10 + 7'(units);
        if (!inrng_reg)
            hum_next = 7'd0;
        else if (hum_raw > hlpc_pkg::HUMID_MAX)
            hum_next = hlpc_pkg::HUMID_MAX;
        else
            hum_next = hum_raw;
    end

    // ------------------------------------------------------------------
    // Stage 4: error times gain, zero unless humidity is above target.
    // ------------------------------------------------------------------
    logic [6:0]  hum4_reg;
    logic [14:0] prod_reg;
    logic [14:0] prod_next;
    logic [6:0]  err;

    always_comb
    begin
        err = hum_reg - target_reg;
        if ((hum_reg != 7'd0) && (hum_reg > target_reg))
            prod_next = 15'(err) * 15'(gain_reg);
        else
            prod_next = 15'd0;
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by ten through the reciprocal multiply.
    // ------------------------------------------------------------------
    logic [6:0]  hum5_reg;
    logic [11:0] quot_reg;
    logic [11:0] quot_next;
    logic [30:0] recip_prod;

    always_comb
    begin
        recip_prod = 31'(prod_reg) * 31'(hlpc_pkg::DIV10_RECIP);
        quot_next  = recip_prod[hlpc_pkg::DIV10_SHIFT +: 12];
    end

    // ------------------------------------------------------------------
    // Stage 6: cap the drive and form the DAC code; this is the output
    // register and holds while the sink stalls.
    // ------------------------------------------------------------------
    logic [6:0] hum6_reg;
    logic [6:0] drive_reg;
    logic [6:0] drive_next;
    logic [7:0] dac_reg;
    logic [7:0] dac_next;

    always_comb
    begin
        if (quot_reg > 12'(hlpc_pkg::DRIVE_CAP))
            drive_next = hlpc_pkg::DRIVE_CAP;
        else
            drive_next = quot_reg[6:0];
        dac_next = hlpc_pkg::DAC_TOP - 8'(drive_next);
    end

    // Payload registers: load on advance, no reset needed.
    always_ff @(posedge clk)
    begin
        if (adv[1])
            freq_reg <= freq_next;
        if (adv[2])
        begin
            inrng_reg <= inrng_next;
            band_reg  <= band_next;
            dist_reg  <= dist_next;
        end
        if (adv[3])
            hum_reg <= hum_next;
        if (adv[4])
        begin
            hum4_reg <= hum_reg;
            prod_reg <= prod_next;
        end
        if (adv[5])
        begin
            hum5_reg <= hum4_reg;
            quot_reg <= quot_next;
        end
        if (adv[6])
        begin
            hum6_reg  <= hum5_reg;
            drive_reg <= drive_next;
            dac_reg   <= dac_next;
        end
    end

    assign humidity    = hum6_reg;
    assign drive_level = drive_reg;
    assign dac_code    = dac_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_dac_sum, clk, rst_n, out_valid,
        (8'(drive_level) + dac_code) == hlpc_pkg::DAC_TOP)
    `ASSERT_IMPLY(a_zero_hum_no_drive, clk, rst_n, out_valid && (humidity == 7'd0),
        drive_level == 7'd0)
    `ASSERT_IMPLY(a_ranges, clk, rst_n, out_valid,
        (drive_level <= hlpc_pkg::DRIVE_CAP) && (humidity <= hlpc_pkg::HUMID_MAX))
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, vld_reg[1])

endmodule

`default_nettype wire
